// File: hdl/cigar_ref_to_query_offset_unit_assert.svh
// Assertion macros used by the checker file of the offset locator.
`ifndef CIGAR_REF_TO_QUERY_OFFSET_UNIT_ASSERT_SVH
`define CIGAR_REF_TO_QUERY_OFFSET_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRO_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRO_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/cro_pkg.sv
// Package: types, opcodes, status codes and limits of the CIGAR offset locator.
`timescale 1ns / 1ps
package cro_pkg;

  localparam int unsigned POS_W = 31;
  localparam int unsigned REF_W = 32;
  localparam int unsigned LEN_W = 28;
  localparam int unsigned OPC_W = 4;
  localparam int unsigned STS_W = 2;

  localparam logic [POS_W-1:0] OFS_MAX = {POS_W{1'b1}};
  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  // CIGAR opcodes
  localparam logic [OPC_W-1:0] OP_M  = 4'd0;
  localparam logic [OPC_W-1:0] OP_I  = 4'd1;
  localparam logic [OPC_W-1:0] OP_D  = 4'd2;
  localparam logic [OPC_W-1:0] OP_N  = 4'd3;
  localparam logic [OPC_W-1:0] OP_S  = 4'd4;
  localparam logic [OPC_W-1:0] OP_H  = 4'd5;
  localparam logic [OPC_W-1:0] OP_P  = 4'd6;
  localparam logic [OPC_W-1:0] OP_EQ = 4'd7;
  localparam logic [OPC_W-1:0] OP_X  = 4'd8;

  // result status codes
  localparam logic [STS_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STS_W-1:0] ST_INTRON = 2'd2;
  localparam logic [STS_W-1:0] ST_DEL    = 2'd3;

  typedef struct packed {
    logic             first_op;
    logic             last_op;
    logic [POS_W-1:0] read_start;
    logic [POS_W-1:0] target_pos;
    logic [OPC_W-1:0] op_code;
    logic [LEN_W-1:0] op_length;
  } item_t;

  typedef struct packed {
    logic [REF_W-1:0] ref_cursor;
    logic [POS_W-1:0] query_cursor;
    logic             resolved;
    logic [POS_W-1:0] saved_target;
  } state_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [POS_W-1:0] query_offset;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
    state_t  state;
  } step_t;

endpackage

// File: hdl/cro_if.sv
// Valid/ready channel interfaces for CIGAR op beats and result beats.
`timescale 1ns / 1ps
interface cro_in_if import cro_pkg::*;;
  logic             valid;
  logic             ready;
  logic             first_op;
  logic             last_op;
  logic [POS_W-1:0] read_start;
  logic [POS_W-1:0] target_pos;
  logic [OPC_W-1:0] op_code;
  logic [LEN_W-1:0] op_length;

  modport source (output valid, first_op, last_op, read_start, target_pos, op_code,
                  op_length, input ready);
  modport sink (input valid, first_op, last_op, read_start, target_pos, op_code,
                op_length, output ready);
endinterface

interface cro_out_if import cro_pkg::*;;
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [POS_W-1:0] query_offset;

  modport source (output valid, status, query_offset, input ready);
  modport sink (input valid, status, query_offset, output ready);
endinterface

// File: hdl/cro_step.sv
// Combinational step: apply one CIGAR op to the cursors and decide the result.
`timescale 1ns / 1ps
module cro_step import cro_pkg::*; (
  input  item_t  item_i,
  input  state_t state_i,
  output step_t  step_o
);

  logic [REF_W-1:0] ref0;
  logic [POS_W-1:0] qry0;
  logic [POS_W-1:0] tgt;
  logic             active;
  logic [REF_W:0]   ref_sum;
  logic [REF_W-1:0] ref_adv;
  logic [POS_W:0]   qry_sum;
  logic [POS_W-1:0] qry_adv;
  logic             hit;
  logic [POS_W-1:0] diff;
  logic [POS_W:0]   off_sum;
  logic [POS_W-1:0] off_sat;
  logic [REF_W-1:0] ref_new;
  logic [POS_W-1:0] qry_new;
  logic             stat_set;
  logic [STS_W-1:0] status;
  logic [POS_W-1:0] offset;

  // a first op reloads the cursors and the target
  always_comb begin
    if (item_i.first_op) begin
      ref0 = {1'b0, item_i.read_start};
      qry0 = '0;
      tgt  = item_i.target_pos;
    end else begin
      ref0 = state_i.ref_cursor;
      qry0 = state_i.query_cursor;
      tgt  = state_i.saved_target;
    end
  end

  assign active  = item_i.first_op || !state_i.resolved;
  assign ref_sum = {1'b0, ref0} + (REF_W+1)'(item_i.op_length);
  assign ref_adv = ref_sum[REF_W] ? REF_MAX : ref_sum[REF_W-1:0];
  assign qry_sum = {1'b0, qry0} + (POS_W+1)'(item_i.op_length);
  assign qry_adv = qry_sum[POS_W] ? OFS_MAX : qry_sum[POS_W-1:0];
  assign hit     = (ref0 <= {1'b0, tgt}) && ({2'b00, tgt} < ref_sum);
  // only used on a hit, where ref0 <= tgt fits in POS_W bits
  assign diff    = tgt - ref0[POS_W-1:0];
  assign off_sum = {1'b0, qry0} + {1'b0, diff};
  assign off_sat = off_sum[POS_W] ? OFS_MAX : off_sum[POS_W-1:0];

  always_comb begin
    ref_new  = ref0;
    qry_new  = qry0;
    stat_set = 1'b0;
    status   = ST_RANGE;
    offset   = '0;
    case (item_i.op_code) inside
      OP_M, OP_EQ, OP_X: begin
        if (hit) begin
          stat_set = 1'b1;
          status   = ST_FOUND;
          offset   = off_sat;
        end else begin
          ref_new = ref_adv;
          qry_new = qry_adv;
        end
      end
      OP_D, OP_N: begin
        ref_new = ref_adv;
        if (ref_adv > {1'b0, tgt}) begin
          stat_set = 1'b1;
          status   = (item_i.op_code == OP_D) ? ST_DEL : ST_INTRON;
        end
      end
      default: begin
        qry_new = qry_adv;
      end
    endcase
    // cursor past the target, or read ended without a hit
    if (!stat_set && ((ref_new > {1'b0, tgt}) || item_i.last_op)) begin
      stat_set = 1'b1;
      status   = ST_RANGE;
    end
  end

  always_comb begin
    step_o.emit             = active && stat_set;
    step_o.res.status       = status;
    step_o.res.query_offset = offset;
    if (active) begin
      step_o.state.ref_cursor   = ref_new;
      step_o.state.query_cursor = qry_new;
      step_o.state.resolved     = stat_set;
      step_o.state.saved_target = tgt;
    end else begin
      step_o.state = state_i;
    end
  end

endmodule

// File: hdl/cigar_ref_to_query_offset_unit.sv
// Top level: CIGAR reference-to-query offset locator with registered in/out.
// A result beat passes the input stage, then the result register, to out_bus.
// Throughput: one op beat per cycle if no result stalls; cursor loop via state_r.
// A stalled result holds only ops that produce a result; dropped ops still flow.
// Reset (rst_n low, synchronous) clears both valid flags and all cursor state.
`timescale 1ns / 1ps
module cigar_ref_to_query_offset_unit import cro_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cro_in_if.sink      in_bus,
  cro_out_if.source   out_bus
);

  // Input stage: holds one op beat ahead of the step logic.
  logic    s1_valid_r, s1_valid_nxt;
  item_t   item_r, item_nxt;

  // Read state: reference cursor, query offset, done flag, target.
  state_t  state_r, state_nxt;

  // Result register: the output side reads straight from here.
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  step_t   step;
  logic    out_free;
  logic    s1_fire;
  logic    in_take;

  cro_step u_step (
    .item_i  (item_r),
    .state_i (state_r),
    .step_o  (step)
  );

  // The result slot frees when empty or drained this cycle. An op that makes
  // no result never waits for it.
  assign out_free = !out_valid_r || out_bus.ready;
  assign s1_fire  = s1_valid_r && (!step.emit || out_free);
  assign in_take  = in_bus.valid && in_bus.ready;

  assign in_bus.ready         = !s1_valid_r || s1_fire;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = res_r.status;
  assign out_bus.query_offset = res_r.query_offset;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    item_nxt     = item_r;
    state_nxt    = state_r;
    out_valid_nxt = out_valid_r;
    res_nxt      = res_r;

    // drain the result register
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    // advance the op held in the input stage
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      state_nxt    = step.state;
      if (step.emit) begin
        out_valid_nxt = 1'b1;
        res_nxt       = step.res;
      end
    end
    // load the next beat
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      item_nxt.first_op   = in_bus.first_op;
      item_nxt.last_op    = in_bus.last_op;
      item_nxt.read_start = in_bus.read_start;
      item_nxt.target_pos = in_bus.target_pos;
      item_nxt.op_code    = in_bus.op_code;
      item_nxt.op_length  = in_bus.op_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

// File: hdl/cro_checker.sv
// Port-level checker for the offset locator, bound to the top level.
`timescale 1ns / 1ps
`include "cigar_ref_to_query_offset_unit_assert.svh"
module cro_checker import cro_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [STS_W-1:0] out_status,
  input logic [POS_W-1:0] out_query_offset
);

  // offset is zero unless the target was found
  `CRO_ASSERT_NOW(a_offset_zero, clk, rst_n, out_valid && (out_status != ST_FOUND), out_query_offset == '0)

  // a new result beat comes from an op beat taken on the input bus
  `CRO_ASSERT_NOW(a_result_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

  // hold a stalled result beat
  `CRO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CRO_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_status) && $stable(out_query_offset))

endmodule

bind cigar_ref_to_query_offset_unit cro_checker u_cro_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_status       (out_bus.status),
  .out_query_offset (out_bus.query_offset)
);
